// ===== sv/e2q_pkg.sv =====
package e2q_pkg;

  localparam int AngW   = 16;
  localparam int CompW  = 16;
  localparam int CordW  = 34;   // x/y datapath, Q30 plus headroom
  localparam int ZW     = 34;   // angle accumulator, rad * 2^30
  localparam int TabLen = 32;
  localparam int StepsDefault = 16;
  localparam int QDepth = 4;

  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [ZW-1:0]    PiQ30     = 34'sd3373259426;
  localparam logic signed [ZW-1:0]    HalfPiQ30 = 34'sd1686629713;

  typedef struct packed {
    logic signed [AngW-1:0] yaw_angle;
    logic signed [AngW-1:0] pitch_angle;
    logic signed [AngW-1:0] roll_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [CompW-1:0] quat_w;
    logic signed [CompW-1:0] quat_x;
    logic signed [CompW-1:0] quat_y;
    logic signed [CompW-1:0] quat_z;
  } e2q_out_t;

  // one prepared angle: reduced half angle and flip flag
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 flip;
  } e2q_ang_t;

  typedef struct packed {
    e2q_ang_t yaw;
    e2q_ang_t pitch;
    e2q_ang_t roll;
  } e2q_prep_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] t [TabLen];
    t = '{34'h3243F6A8, 34'h1DAC6705, 34'h0FADBAFC, 34'h07F56EA6, 34'h03FEAB76,
          34'h01FFD55B, 34'h00FFFAAA, 34'h007FFF55, 34'h003FFFEA, 34'h001FFFFD,
          34'h000FFFFF, 34'h0007FFFF, 34'h0003FFFF, 34'h0001FFFF, 34'h0000FFFF,
          34'h00007FFF, 34'h00003FFF, 34'h00001FFF, 34'h00000FFF, 34'h000007FF,
          34'h000003FF, 34'h000001FF, 34'h000000FF, 34'h0000007F, 34'h0000003F,
          34'h0000001F, 34'h0000000F, 34'h00000008, 34'h00000004, 34'h00000002,
          34'h00000001, 34'h00000000};
    return t[i % TabLen];
  endfunction

endpackage

// ===== sv/euler_to_quaternion.sv =====
// Channel | Ports                            | Beat
// input   | start, busy, in_data             | start & !busy
// result  | out_strobe, out_data             | one cycle, cannot be held off
//
// One angle triple accepted per cycle while busy is low. Pipeline: one
// front stage (half angle, quadrant fold), queue, CORDIC_STEPS+1 rotation
// stages, one sign-flip stage, two multiply stages and one round/saturate.
// Synchronous active-low reset clears valid tracking only.
// The result side never stalls, so busy is only raised by a full queue,
// which cannot happen in steady state.
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = e2q_pkg::StepsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  e2q_pkg::e2q_in_t  in_data,
  output logic              out_strobe,
  output e2q_pkg::e2q_out_t out_data
);
  import e2q_pkg::*;

  logic      acc;
  logic      pv_valid_r, q_valid, q_full;
  e2q_prep_t pv_data_r, q_data;

  assign acc  = start & ~busy;
  assign busy = q_full;

  e2q_front u_front (
    .clk, .rst_n, .in_valid(acc), .in_data,
    .pv_valid_r, .pv_data_r
  );

  e2q_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .wr_en(pv_valid_r), .wr_data(pv_data_r),
    .rd_valid(q_valid), .rd_data(q_data), .full(q_full)
  );

  e2q_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .pv_valid(q_valid), .pv_data(q_data),
    .out_strobe, .out_data
  );

  // queue drains each cycle, so it never fills
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled");
  // accepted beat reaches the queue next cycle
  a_front: assert property (@(posedge clk) disable iff (!rst_n) acc |=> pv_valid_r)
    else $error("front lost a beat");
  a_queue_wr: assert property (@(posedge clk) disable iff (!rst_n) pv_valid_r |=> q_valid)
    else $error("queue lost a beat");
endmodule

// ===== sv/e2q_front.sv =====
module e2q_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  e2q_pkg::e2q_in_t   in_data,
  output logic               pv_valid_r,
  output e2q_pkg::e2q_prep_t pv_data_r
);
  import e2q_pkg::*;

  function automatic e2q_ang_t prep(input logic signed [AngW-1:0] a);
    e2q_ang_t r;
    logic signed [ZW-1:0] z;
    z = ZW'(a) <<< 16;
    r.flip = 1'b0;
    r.z    = z;
    if (z > HalfPiQ30) begin
      r.z = z - PiQ30; r.flip = 1'b1;
    end else if (z < -HalfPiQ30) begin
      r.z = z + PiQ30; r.flip = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) pv_valid_r <= 1'b0;
    else        pv_valid_r <= in_valid;
    pv_data_r.yaw   <= prep(in_data.yaw_angle);
    pv_data_r.pitch <= prep(in_data.pitch_angle);
    pv_data_r.roll  <= prep(in_data.roll_angle);
  end
endmodule

// ===== sv/e2q_queue.sv =====
module e2q_queue #(
  parameter int Depth = e2q_pkg::QDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  e2q_pkg::e2q_prep_t wr_data,
  output logic               rd_valid,
  output e2q_pkg::e2q_prep_t rd_data,
  output logic               full
);
  import e2q_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  e2q_prep_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];
  assign full     = cnt_r == (AW+1)'(Depth);

  // the back end never stalls: every valid head pops the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd_valid) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_valid);
    end
  end
endmodule

// ===== sv/e2q_back.sv =====
module e2q_back #(
  parameter int CordicSteps = e2q_pkg::StepsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pv_valid,
  input  e2q_pkg::e2q_prep_t pv_data,
  output logic               out_strobe,
  output e2q_pkg::e2q_out_t  out_data
);
  import e2q_pkg::*;
  localparam int N = CordicSteps;
  localparam int PW = 2*CordW;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    flip;
  } cst_t;

  cst_t cs_r [3][N+1];

  // CORDIC stage 0 loads
  always_ff @(posedge clk) begin
    cs_r[0][0] <= '{GainQ30, '0, pv_data.yaw.z,   pv_data.yaw.flip};
    cs_r[1][0] <= '{GainQ30, '0, pv_data.pitch.z, pv_data.pitch.flip};
    cs_r[2][0] <= '{GainQ30, '0, pv_data.roll.z,  pv_data.roll.flip};
  end

  for (genvar a = 0; a < 3; a++) begin : g_ang
    for (genvar i = 0; i < N; i++) begin : g_stg
      always_ff @(posedge clk) begin
        cs_r[a][i+1].flip <= cs_r[a][i].flip;
        if (cs_r[a][i].z >= 0) begin
          cs_r[a][i+1].x <= cs_r[a][i].x - (cs_r[a][i].y >>> i);
          cs_r[a][i+1].y <= cs_r[a][i].y + (cs_r[a][i].x >>> i);
          cs_r[a][i+1].z <= cs_r[a][i].z - atan_q30(i);
        end else begin
          cs_r[a][i+1].x <= cs_r[a][i].x + (cs_r[a][i].y >>> i);
          cs_r[a][i+1].y <= cs_r[a][i].y - (cs_r[a][i].x >>> i);
          cs_r[a][i+1].z <= cs_r[a][i].z + atan_q30(i);
        end
      end
    end
  end

  // sin/cos with the flip applied
  logic signed [CordW-1:0] c_r [3], s_r [3];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      c_r[a] <= cs_r[a][N].flip ? -cs_r[a][N].x : cs_r[a][N].x;
      s_r[a] <= cs_r[a][N].flip ? -cs_r[a][N].y : cs_r[a][N].y;
    end
  end

  // pair products yaw*pitch, rounded to Q30: cc, sc, cs, ss
  logic signed [CordW-1:0] pp_r [4];
  logic signed [CordW-1:0] cr_d_r, sr_d_r;
  function automatic logic signed [CordW-1:0] rmul(input logic signed [CordW-1:0] a,
                                                    input logic signed [CordW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
    return CordW'(p >>> 30);
  endfunction
  always_ff @(posedge clk) begin
    pp_r[0] <= rmul(c_r[0], c_r[1]);
    pp_r[1] <= rmul(s_r[0], c_r[1]);
    pp_r[2] <= rmul(c_r[0], s_r[1]);
    pp_r[3] <= rmul(s_r[0], s_r[1]);
    cr_d_r  <= c_r[2];
    sr_d_r  <= s_r[2];
  end

  // triple products (Q60): t[k][0]=*cr, t[k][1]=*sr
  logic signed [PW-1:0] t_r [4][2];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      t_r[k][0] <= PW'(pp_r[k]) * PW'(cr_d_r);
      t_r[k][1] <= PW'(pp_r[k]) * PW'(sr_d_r);
    end
  end

  function automatic logic signed [CompW-1:0] q14(input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + ((PW+1)'(1) <<< 45)) >>> 46;
    if (r > 32767)       return 16'sh7fff;
    else if (r < -32768) return 16'sh8000;
    else                 return CompW'(r);
  endfunction

  e2q_out_t o_r;
  always_ff @(posedge clk) begin
    o_r.quat_w <= q14((PW+1)'(t_r[0][0]) + (PW+1)'(t_r[3][1]));
    o_r.quat_x <= q14((PW+1)'(t_r[0][1]) - (PW+1)'(t_r[3][0]));
    o_r.quat_y <= q14((PW+1)'(t_r[1][1]) + (PW+1)'(t_r[2][0]));
    o_r.quat_z <= q14((PW+1)'(t_r[1][0]) - (PW+1)'(t_r[2][1]));
  end

  // valid pipe: N+1 cordic regs, sincos, pair, triple, out
  logic [N+4:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[N+3:0], pv_valid};
  end
  assign out_strobe = v_r[N+4];
  assign out_data   = o_r;
endmodule
